[hw/rtl/assert_macros.svh]
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LVCP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while in reset
`define LVCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/lvcp_pkg.sv]
// shared constants, types and helpers of the letter/value command parser
`default_nettype none

package lvcp_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int SLOTS_PER_CASE = 26;
   localparam int SLOT_COUNT     = 2 * SLOTS_PER_CASE;
   localparam int SLOT_BITS      = 6;
   localparam int DATA_BITS      = 32;
   localparam int MAG_BITS       = DATA_BITS - 1;
   localparam int CHAR_BITS      = 8;
   localparam int WEIGHT_BITS    = FRAC_BITS + 1;

   localparam logic [SLOT_BITS-1:0] NO_SLOT = SLOT_BITS'(63);
   localparam logic [CHAR_BITS-1:0] END_CHAR_RESET = 8'd13;

   localparam logic FUNC_FEED = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   localparam logic [CHAR_BITS-1:0] CHAR_LA    = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_LZ    = 8'h7A;
   localparam logic [CHAR_BITS-1:0] CHAR_UA    = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_UZ    = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CHAR_0     = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_9     = 8'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_POINT = 8'h2E;

   // weight of the first fraction digit: one tenth of one unit, rounded
   localparam int FIRST_WEIGHT = ((1 << FRAC_BITS) + 5) / 10;

   // divide by ten as a multiply by a rounded-up reciprocal and a shift
   localparam int DIV_SHIFT   = FRAC_BITS + 6;
   localparam int DIV10_BITS  = FRAC_BITS + 6;
   localparam longint unsigned DIV10_MUL = ((longint'(1) << DIV_SHIFT) + 9) / 10;

   typedef struct packed {
      logic                 wr_en;
      logic [SLOT_BITS-1:0] wr_slot;
      logic [DATA_BITS-1:0] wr_data;
      logic                 rd_en;
      logic [SLOT_BITS-1:0] rd_slot;
      logic                 bad;
   } lvcp_op_type;

   // slot of a letter, lower case first, or NO_SLOT
   function automatic logic [SLOT_BITS-1:0] letter_slot(input logic [CHAR_BITS-1:0] c);
      logic [SLOT_BITS-1:0] s;
      s = NO_SLOT;
      if (c >= CHAR_LA && c <= CHAR_LZ) begin
         s = SLOT_BITS'(c - CHAR_LA);
      end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
         s = SLOT_BITS'(c - CHAR_UA) + SLOT_BITS'(SLOTS_PER_CASE);
      end
      return s;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/letter_value_command_parser_core.sv]
// Letter/value command parser: characters in on req_, one result per item on rsp_.
// req_func 0 feeds req_char_in to the parser; a letter names one of 52 slots,
// minus signs right after it flip the sign, digits and a point build a signed
// Q15.16 number, and the terminator in csr_wr_data (written with csr_wr_en,
// reset 13) stores it into the named slot. req_func 1 reads the slot named by
// req_char_in on rsp_read_data (zero for a non-letter). rsp_bad_char flags an
// unrecognized fed character.
// Every item gives exactly one result, in order. The slot memory is read at the
// edge that accepts an item into the memory-read stage, and the output register
// loads from that stage once it is empty or being emptied; the result then shows
// on rsp_. Throughput is one item per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its result and one more
// item moves into the memory-read stage; req_ready then drops until rsp_ready.
// Reset clears the pending number, leaves no slot named, sets the terminator to
// 13, and makes every slot read as zero (per-slot valid bits, no clearing pass).
// The terminator may only be changed while no transfer is in flight.
`default_nettype none

module letter_value_command_parser_core import lvcp_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_func,
   input  wire logic [CHAR_BITS-1:0] req_char_in,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic signed [DATA_BITS-1:0] rsp_read_data,
   output logic                      rsp_bad_char,
   input  wire logic                 csr_wr_en,
   input  wire logic [CHAR_BITS-1:0] csr_wr_data
);

   logic [CHAR_BITS-1:0] end_char_ff;
   lvcp_op_type          op;
   logic                 fire;
   logic                 p1_adv;
   logic [DATA_BITS-1:0] store_rd_data;

   logic                 p1_valid_ff, p1_valid_in;
   logic                 p1_bad_ff, p1_bad_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                 rsp_bad_ff, rsp_bad_in;

   // read stage moves on when the output register is empty or being emptied
   assign p1_adv    = p1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !p1_valid_ff || p1_adv;
   assign fire      = req_valid && req_ready;

   lvcp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .func     (req_func),
      .char_in  (req_char_in),
      .end_char (end_char_ff),
      .op       (op)
   );

   lvcp_slot_store u_store (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .op      (op),
      .rd_data (store_rd_data)
   );

   always_comb begin
      p1_valid_in  = p1_valid_ff;
      p1_bad_in    = p1_bad_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_bad_in   = rsp_bad_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (p1_adv) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = store_rd_data;
         rsp_bad_in   = p1_bad_ff;
         p1_valid_in  = 1'b0;
      end
      if (fire) begin
         p1_valid_in = 1'b1;
         p1_bad_in   = op.bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         end_char_ff  <= END_CHAR_RESET;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            end_char_ff <= csr_wr_data;
         end
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_bad_ff   <= p1_bad_in;
      rsp_data_ff <= rsp_data_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_bad_char  = rsp_bad_ff;

endmodule

`default_nettype wire

[hw/rtl/lvcp_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module lvcp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/lvcp_parser.sv]
// character decoder and pending-number state of the command parser
`default_nettype none

module lvcp_parser import lvcp_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire logic                 func,
   input  wire logic [CHAR_BITS-1:0] char_in,
   input  wire logic [CHAR_BITS-1:0] end_char,
   output lvcp_op_type               op
);

   localparam int INT_SUM_BITS  = MAG_BITS + 5;
   localparam int FRAC_PRD_BITS = WEIGHT_BITS + 4;
   localparam int PROD_BITS     = WEIGHT_BITS + 1 + DIV10_BITS;

   logic [MAG_BITS-1:0]    accum_ff, accum_in;
   logic [WEIGHT_BITS-1:0] weight_ff, weight_in;
   logic                   in_frac_ff, in_frac_in;
   logic                   neg_ff, neg_in;
   logic                   after_letter_ff, after_letter_in;
   logic [SLOT_BITS-1:0]   target_ff, target_in;

   logic [SLOT_BITS-1:0]     slot;
   logic                     is_letter;
   logic                     is_digit;
   logic [3:0]               digit;
   logic [INT_SUM_BITS-1:0]  int_sum;
   logic [MAG_BITS-1:0]      int_sat;
   logic [FRAC_PRD_BITS-1:0] frac_prod;
   logic [MAG_BITS:0]        frac_sum;
   logic [MAG_BITS-1:0]      frac_sat;
   logic [WEIGHT_BITS:0]     weight_plus;
   logic [PROD_BITS-1:0]     div_prod;
   logic [WEIGHT_BITS-1:0]   weight_next;
   logic [DATA_BITS-1:0]     magnitude;

   assign slot      = letter_slot(char_in);
   assign is_letter = (slot != NO_SLOT);
   assign is_digit  = (char_in >= CHAR_0) && (char_in <= CHAR_9);
   assign digit     = 4'(char_in - CHAR_0);

   // integer digit: accum * 10 as two shifts, plus the digit in whole units
   assign int_sum = (INT_SUM_BITS'(accum_ff) << 3) + (INT_SUM_BITS'(accum_ff) << 1)
                  + (INT_SUM_BITS'(digit) << FRAC_BITS);
   assign int_sat = (int_sum > INT_SUM_BITS'({MAG_BITS{1'b1}})) ? {MAG_BITS{1'b1}}
                                                              : int_sum[MAG_BITS-1:0];

   // fraction digit uses the weight already scaled for this position
   assign frac_prod = FRAC_PRD_BITS'(weight_ff) * FRAC_PRD_BITS'(digit);
   assign frac_sum  = (MAG_BITS+1)'(accum_ff) + (MAG_BITS+1)'(frac_prod);
   assign frac_sat  = frac_sum[MAG_BITS] ? {MAG_BITS{1'b1}} : frac_sum[MAG_BITS-1:0];

   // weight of the following position, (w + 5) / 10, in parallel with the add
   assign weight_plus = (WEIGHT_BITS+1)'(weight_ff) + (WEIGHT_BITS+1)'(5);
   assign div_prod    = PROD_BITS'(weight_plus) * PROD_BITS'(DIV10_MUL);
   assign weight_next = div_prod[DIV_SHIFT +: WEIGHT_BITS];

   assign magnitude = {1'b0, accum_ff};

   always_comb begin
      accum_in        = accum_ff;
      weight_in       = weight_ff;
      in_frac_in      = in_frac_ff;
      neg_in          = neg_ff;
      after_letter_in = after_letter_ff;
      target_in       = target_ff;
      op              = '0;
      op.wr_slot      = target_ff;
      op.wr_data      = neg_ff ? (DATA_BITS'(0) - magnitude) : magnitude;
      op.rd_slot      = slot;

      if (func == FUNC_READ) begin
         op.rd_en = is_letter;
      end else if (char_in == end_char) begin
         // terminator wins over every other meaning of the character
         op.wr_en   = (target_ff != NO_SLOT);
         accum_in   = '0;
         weight_in  = '0;
         in_frac_in = 1'b0;
         neg_in     = 1'b0;
         target_in  = NO_SLOT;
      end else if (is_digit) begin
         after_letter_in = 1'b0;
         if (!in_frac_ff) begin
            accum_in = int_sat;
         end else begin
            accum_in  = frac_sat;
            weight_in = weight_next;
         end
      end else if (is_letter) begin
         accum_in        = '0;
         weight_in       = '0;
         in_frac_in      = 1'b0;
         neg_in          = 1'b0;
         target_in       = slot;
         after_letter_in = 1'b1;
      end else if (char_in == CHAR_MINUS && after_letter_ff) begin
         neg_in = !neg_ff;
      end else if (char_in == CHAR_POINT) begin
         after_letter_in = 1'b0;
         in_frac_in      = 1'b1;
         weight_in       = WEIGHT_BITS'(FIRST_WEIGHT);
      end else begin
         op.bad = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff        <= '0;
         weight_ff       <= '0;
         in_frac_ff      <= 1'b0;
         neg_ff          <= 1'b0;
         after_letter_ff <= 1'b0;
         target_ff       <= NO_SLOT;
      end else if (fire) begin
         accum_ff        <= accum_in;
         weight_ff       <= weight_in;
         in_frac_ff      <= in_frac_in;
         neg_ff          <= neg_in;
         after_letter_ff <= after_letter_in;
         target_ff       <= target_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/lvcp_slot_store.sv]
// variable slot memory with per-slot valid bits standing in for reset
`default_nettype none

module lvcp_slot_store import lvcp_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  lvcp_op_type               op,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [SLOT_COUNT-1:0] valid_ff;
   logic                  hit_ff, hit_in;
   logic                  wr_en;
   logic                  rd_en;
   logic [DATA_BITS-1:0]  ram_rd_data;

   assign wr_en  = fire && op.wr_en;
   assign rd_en  = fire && op.rd_en;
   // never-written slot reads as zero
   assign hit_in = op.rd_en && valid_ff[op.rd_slot];

   lvcp_ram #(
      .WIDTH (DATA_BITS),
      .DEPTH (SLOT_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (op.wr_slot),
      .wr_data (op.wr_data),
      .rd_en   (rd_en),
      .rd_addr (op.rd_slot),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[op.wr_slot] <= 1'b1;
         end
         if (fire) begin
            hit_ff <= hit_in;
         end
      end
   end

   assign rd_data = hit_ff ? ram_rd_data : '0;

endmodule

`default_nettype wire

[hw/rtl/lvcp_checker.sv]
// port-level checks of the command parser, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module lvcp_checker import lvcp_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [DATA_BITS-1:0] rsp_read_data,
   input wire logic                 rsp_bad_char
);

   // a flagged character is a feed, which never carries read data
   `LVCP_ASSERT_IMPL(a_bad_has_no_data, clock, reset,
      rsp_valid && rsp_bad_char, rsp_read_data == '0,
      "bad character result carries data")

   // input only backs up when the output is full and stalled
   `LVCP_ASSERT_IMPL(a_ready_only_on_stall, clock, reset,
      !req_ready, rsp_valid && !rsp_ready,
      "input stalled without output stall")

   // every transfer in is followed by a result on rsp_
   `LVCP_ASSERT_IMPL(a_result_latency, clock, reset,
      req_valid && req_ready, ##2 rsp_valid,
      "no result two cycles after input transfer")

   // stalled result holds
   `LVCP_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_read_data) && $stable(rsp_bad_char),
      "stalled result changed")

endmodule

bind letter_value_command_parser_core lvcp_checker u_checker (.*);

`default_nettype wire
